@@ hdl/ovl_pkg.sv @@
// Shared constants, codes and types for the ordered value list.
`timescale 1ns / 1ps

package ovl_pkg;

  // List capacity and derived widths
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths of the channels
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  // Per-transaction control broadcast to every cell
  typedef struct packed {
    logic append_go;
    logic remove_go;
  } cell_ctl_t;

endpackage

@@ hdl/ovl_in_if.sv @@
// Input channel: operation kind and value with valid/ready handshake.
`timescale 1ns / 1ps

interface ovl_in_if;
  logic                         valid;
  logic                         ready;
  logic [ovl_pkg::KIND_W-1:0]   kind;
  logic signed [ovl_pkg::VALUE_W-1:0] item_value;

  modport source (output valid, output kind, output item_value, input ready);
  modport sink   (input valid, input kind, input item_value, output ready);
endinterface

@@ hdl/ovl_out_if.sv @@
// Result channel: status, position, entry count and empty flag.
`timescale 1ns / 1ps

interface ovl_out_if;
  logic                          valid;
  logic                          ready;
  logic [ovl_pkg::STATUS_W-1:0]  status;
  logic [ovl_pkg::POS_W-1:0]     position;
  logic [ovl_pkg::COUNT_W-1:0]   entry_count;
  logic                          is_empty;

  modport source (output valid, output status, output position, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  input is_empty, output ready);
endinterface

@@ hdl/ovl_cell.sv @@
// One list cell: holds a value, compares it and shifts toward the head on remove.
`timescale 1ns / 1ps

module ovl_cell (
  input  logic                                clk,
  input  ovl_pkg::cell_ctl_t                  ctl,
  input  logic                                occupied,
  input  logic                                is_tail,
  input  logic signed [ovl_pkg::VALUE_W-1:0]  item_value,
  input  logic signed [ovl_pkg::VALUE_W-1:0]  right_value,
  input  logic                                seen_in,
  output logic                                seen_out,
  output logic                                match,
  output logic signed [ovl_pkg::VALUE_W-1:0]  value
);

  logic signed [ovl_pkg::VALUE_W-1:0] value_r;
  logic signed [ovl_pkg::VALUE_W-1:0] value_nxt;

  // Compare against the searched value; only held entries count
  assign match    = occupied && (value_r == item_value);
  assign seen_out = seen_in || match;
  assign value    = value_r;

  // Append writes the tail slot; remove pulls from the right at and past the hit
  always_comb begin
    value_nxt = value_r;
    if (ctl.append_go && is_tail) begin
      value_nxt = item_value;
    end else if (ctl.remove_go && seen_out) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

@@ hdl/ordered_value_list_top.sv @@
// Ordered value list: a row of compare-and-shift cells with a registered result.
// The result is registered when the input transaction is accepted and is valid in the cycle after it.
// Throughput: one operation per cycle while out_ch takes each result; all cells compare
// and shift in parallel, bounded by the leftmost-match chain across the cell row.
// Reset: synchronous active-low rst_n empties the list and drops any pending result;
// cell values are undefined until written and need no clearing.
`timescale 1ns / 1ps

module ordered_value_list_top (
  input  logic     clk,
  input  logic     rst_n,
  ovl_in_if.sink   in_ch,
  ovl_out_if.source out_ch
);

  localparam int DEPTH = ovl_pkg::DEPTH;

  logic [ovl_pkg::CNT_W-1:0] count_r;
  logic [ovl_pkg::CNT_W-1:0] count_nxt;

  logic                              out_valid_r;
  logic [ovl_pkg::STATUS_W-1:0]      status_r;
  logic [ovl_pkg::POS_W-1:0]         position_r;
  logic [ovl_pkg::COUNT_W-1:0]       entry_count_r;
  logic                              is_empty_r;
  logic [ovl_pkg::STATUS_W-1:0]      status_nxt;
  logic [ovl_pkg::POS_W-1:0]         position_nxt;

  logic                        accept;
  logic                        full;
  logic                        found;
  logic                        do_append;
  logic                        do_remove;
  logic [ovl_pkg::IDX_W-1:0]   hit_idx;
  ovl_pkg::cell_ctl_t          ctl;

  logic [DEPTH-1:0] occupied;
  logic [DEPTH-1:0] is_tail;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] first_hit;
  logic [DEPTH:0]   seen;
  logic signed [ovl_pkg::VALUE_W-1:0] cell_value [DEPTH];

  // Handshake: take a new transaction whenever the result register frees up
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Occupancy and tail position from the count
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occupied[i] = ovl_pkg::CNT_W'(i) < count_r;
      is_tail[i]  = ovl_pkg::CNT_W'(i) == count_r;
    end
  end

  assign full = count_r == ovl_pkg::CNT_W'(DEPTH);

  // Cell row; the seen chain marks cells at and right of the leftmost match
  assign seen[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [ovl_pkg::VALUE_W-1:0] right_value;
    if (g == DEPTH - 1) begin : g_last
      assign right_value = cell_value[g];
    end else begin : g_mid
      assign right_value = cell_value[g+1];
    end

    ovl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occupied[g]),
      .is_tail    (is_tail[g]),
      .item_value (in_ch.item_value),
      .right_value(right_value),
      .seen_in    (seen[g]),
      .seen_out   (seen[g+1]),
      .match      (match[g]),
      .value      (cell_value[g])
    );
  end

  // Leftmost match index from the one-hot first hit
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      first_hit[i] = match[i] && !seen[i];
      if (first_hit[i]) begin
        hit_idx = hit_idx | ovl_pkg::IDX_W'(i);
      end
    end
  end

  assign found = seen[DEPTH];

  // Operation decode and result fields
  always_comb begin
    do_append    = 1'b0;
    do_remove    = 1'b0;
    status_nxt   = ovl_pkg::STATUS_DONE;
    position_nxt = '0;
    case (ovl_pkg::kind_t'(in_ch.kind))
      ovl_pkg::KIND_APPEND: begin
        if (full) begin
          status_nxt = ovl_pkg::STATUS_FULL;
        end else begin
          do_append = 1'b1;
        end
      end
      ovl_pkg::KIND_REMOVE: begin
        if (found) begin
          do_remove = 1'b1;
        end else begin
          status_nxt = ovl_pkg::STATUS_NOT_FOUND;
        end
      end
      ovl_pkg::KIND_FIND: begin
        if (found) begin
          position_nxt = ovl_pkg::POS_W'(hit_idx);
        end else begin
          status_nxt = ovl_pkg::STATUS_NOT_FOUND;
        end
      end
      default: begin
        status_nxt = ovl_pkg::STATUS_DONE;
      end
    endcase
  end

  assign ctl.append_go = accept && do_append;
  assign ctl.remove_go = accept && do_remove;

  // Next count
  always_comb begin
    count_nxt = count_r;
    if (ctl.append_go) begin
      count_nxt = count_r + ovl_pkg::CNT_W'(1);
    end else if (ctl.remove_go) begin
      count_nxt = count_r - ovl_pkg::CNT_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      position_r    <= position_nxt;
      entry_count_r <= ovl_pkg::COUNT_W'(count_nxt);
      is_empty_r    <= count_nxt == '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.position    = position_r;
  assign out_ch.entry_count = entry_count_r;
  assign out_ch.is_empty    = is_empty_r;

endmodule

@@ verif/ordered_value_list_top_tb.sv @@
// Self-checking testbench for the ordered value list: random and directed operations.
`timescale 1ns / 1ps

module ordered_value_list_top_tb;

  // Run control
  localparam int RANDOM_OPS     = 1400;
  localparam int SEGMENT_LEN    = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  // Unused kind encoding, treated by the block as a no-op
  localparam logic [ovl_pkg::KIND_W-1:0] KIND_NOP = 2'd3;

  localparam logic signed [ovl_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ovl_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [ovl_pkg::KIND_W-1:0]         kind;
    logic signed [ovl_pkg::VALUE_W-1:0] value;
    int                                 gap_after;
  } list_op_t;

  typedef struct {
    ovl_pkg::status_t              status;
    logic [ovl_pkg::POS_W-1:0]     position;
    logic [ovl_pkg::COUNT_W-1:0]   entry_count;
    logic                          is_empty;
  } list_result_t;

  logic clk;
  logic rst_n;

  ovl_in_if  in_bus ();
  ovl_out_if out_bus ();

  ordered_value_list_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Operations waiting to be driven, and results predicted but not yet seen
  list_op_t     queued_ops[$];
  list_result_t pending_results[$];

  // Predictor state: the list contents, head first
  logic signed [ovl_pkg::VALUE_W-1:0] held_values[$];

  int  ops_total;
  int  ops_accepted;
  int  mismatch_count;
  int  idle_cycles;
  int  in_wait;
  int  out_wait;
  int  out_results_seen;
  bit  out_calm;
  logic in_fired;
  logic out_fired;

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Apply one operation to the predicted list and return its result
  task automatic apply_list_op(input logic [ovl_pkg::KIND_W-1:0] kind,
                               input logic signed [ovl_pkg::VALUE_W-1:0] value,
                               output list_result_t res);
    int hit;
    hit = -1;
    res.status   = ovl_pkg::STATUS_DONE;
    res.position = '0;
    if (kind == ovl_pkg::KIND_REMOVE || kind == ovl_pkg::KIND_FIND) begin
      foreach (held_values[i]) begin
        if (hit < 0 && held_values[i] == value) hit = i;
      end
    end
    case (kind)
      ovl_pkg::KIND_APPEND: begin
        if (held_values.size() >= ovl_pkg::DEPTH) res.status = ovl_pkg::STATUS_FULL;
        else held_values.push_back(value);
      end
      ovl_pkg::KIND_REMOVE: begin
        if (hit < 0) res.status = ovl_pkg::STATUS_NOT_FOUND;
        else held_values.delete(hit);
      end
      ovl_pkg::KIND_FIND: begin
        if (hit < 0) res.status = ovl_pkg::STATUS_NOT_FOUND;
        else res.position = hit[ovl_pkg::POS_W-1:0];
      end
      default: ;
    endcase
    res.entry_count = ovl_pkg::COUNT_W'(held_values.size());
    res.is_empty    = (held_values.size() == 0);
  endtask

  function automatic int draw_gap(bit no_idle);
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic void add_op(logic [ovl_pkg::KIND_W-1:0] kind,
                                 logic signed [ovl_pkg::VALUE_W-1:0] value,
                                 bit no_idle);
    list_op_t op;
    op.kind      = kind;
    op.value     = value;
    op.gap_after = draw_gap(no_idle);
    queued_ops.push_back(op);
  endfunction

  // Input driver: presents one transaction at a time, with a random idle gap (possibly none) after each
  always @(negedge clk) begin
    list_op_t op;
    if (rst_n) begin
      if (!in_bus.valid || in_fired) begin
        if (in_wait > 0) begin
          in_bus.valid <= 1'b0;
          in_wait = in_wait - 1;
        end else if (queued_ops.size() > 0) begin
          op = queued_ops.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.kind       <= op.kind;
          in_bus.item_value <= op.value;
          in_wait = op.gap_after;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready driver: after each result, drops ready for a random gap from draw_gap (none when calm)
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fired) begin
        out_results_seen = out_results_seen + 1;
        if (out_results_seen % 50 == 0) out_calm = ($urandom_range(0, 3) == 0);
        out_wait = draw_gap(out_calm);
      end
      if (out_wait > 0) begin
        out_bus.ready <= 1'b0;
        out_wait = out_wait - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on accepted inputs, check accepted results
  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst_n) begin
      in_fired    <= 1'b0;
      out_fired   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_fired  <= in_bus.valid && in_bus.ready;
      out_fired <= out_bus.valid && out_bus.ready;

      if (in_bus.valid && in_bus.ready) begin
        apply_list_op(in_bus.kind, in_bus.item_value, exp_res);
        pending_results.push_back(exp_res);
        ops_accepted <= ops_accepted + 1;
      end

      if (out_bus.valid && out_bus.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no pending expectation");
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_bus.status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, out_bus.status);
            mismatch_count <= mismatch_count + 1;
          end
          if (out_bus.position !== exp_res.position) begin
            $error("position: expected %0d, actual %0d", exp_res.position, out_bus.position);
            mismatch_count <= mismatch_count + 1;
          end
          if (out_bus.entry_count !== exp_res.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   exp_res.entry_count, out_bus.entry_count);
            mismatch_count <= mismatch_count + 1;
          end
          if (out_bus.is_empty !== exp_res.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", exp_res.is_empty, out_bus.is_empty);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end

      // Watchdog: cycles with no transaction on either channel
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus build, reset and end of run
  initial begin
    logic signed [ovl_pkg::VALUE_W-1:0] pool[6];
    logic signed [ovl_pkg::VALUE_W-1:0] val;
    logic [ovl_pkg::KIND_W-1:0]         kind;
    int  phase;
    int  pick;
    bit  no_idle;

    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.kind       = ovl_pkg::KIND_APPEND;
    in_bus.item_value = '0;
    out_bus.ready     = 1'b0;
    in_fired          = 1'b0;
    out_fired         = 1'b0;
    in_wait           = 0;
    out_wait          = 0;
    out_results_seen  = 0;
    out_calm          = 1'b0;
    ops_accepted      = 0;
    mismatch_count    = 0;
    idle_cycles       = 0;

    // Directed: empty-list misses, extremes, duplicates, fill to full
    add_op(ovl_pkg::KIND_FIND,   VAL_MIN, 1'b0);
    add_op(ovl_pkg::KIND_REMOVE, VAL_MAX, 1'b0);
    add_op(KIND_NOP,             '1,      1'b0);
    add_op(ovl_pkg::KIND_APPEND, VAL_MIN, 1'b0);
    add_op(ovl_pkg::KIND_APPEND, VAL_MAX, 1'b0);
    add_op(ovl_pkg::KIND_APPEND, '0,      1'b0);
    add_op(ovl_pkg::KIND_APPEND, -1,      1'b0);
    add_op(ovl_pkg::KIND_APPEND, VAL_MIN, 1'b0);
    add_op(ovl_pkg::KIND_FIND,   VAL_MIN, 1'b0);
    add_op(ovl_pkg::KIND_FIND,   -1,      1'b0);
    add_op(ovl_pkg::KIND_REMOVE, VAL_MIN, 1'b0);
    add_op(ovl_pkg::KIND_FIND,   VAL_MIN, 1'b0);
    add_op(ovl_pkg::KIND_FIND,   32'sd5,  1'b0);
    for (int i = 0; i < ovl_pkg::DEPTH - 4; i++)
      add_op(ovl_pkg::KIND_APPEND, 32'sd100 + i, 1'b1);
    add_op(ovl_pkg::KIND_APPEND, VAL_MAX, 1'b0);
    add_op(ovl_pkg::KIND_FIND,   32'sd100 + ovl_pkg::DEPTH - 5, 1'b0);
    add_op(KIND_NOP,             VAL_MIN, 1'b0);

    // Random: phases that fill, drain or mix, values mostly from a small pool
    pool[0] = VAL_MIN;
    pool[1] = VAL_MAX;
    for (int i = 2; i < 6; i++) pool[i] = $urandom;
    phase   = 0;
    no_idle = 1'b0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % SEGMENT_LEN == 0) begin
        phase   = $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      case (phase)
        0:       kind = (pick < 60) ? ovl_pkg::KIND_APPEND :
                        (pick < 80) ? ovl_pkg::KIND_REMOVE : ovl_pkg::KIND_FIND;
        1:       kind = (pick < 25) ? ovl_pkg::KIND_APPEND :
                        (pick < 75) ? ovl_pkg::KIND_REMOVE : ovl_pkg::KIND_FIND;
        default: kind = (pick < 40) ? ovl_pkg::KIND_APPEND :
                        (pick < 70) ? ovl_pkg::KIND_REMOVE : ovl_pkg::KIND_FIND;
      endcase
      if ($urandom_range(0, 49) == 0) kind = KIND_NOP;
      pick = $urandom_range(0, 9);
      if (pick < 7)       val = pool[$urandom_range(0, 5)];
      else if (pick == 7) val = $urandom_range(0, 3);
      else                val = $urandom;
      add_op(kind, val, no_idle);
    end
    ops_total = queued_ops.size();

    // Reset
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every operation to be accepted and every result checked
    while (!(ops_accepted == ops_total && pending_results.size() == 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ordered_value_list_top_tb failed");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
        $display("ordered_value_list_top_tb passed");
      end else begin
        $display("ordered_value_list_top_tb failed");
      end
    end
    $finish;
  end

endmodule
